// ----- rtl/btfm_pkg.sv -----
// Shared types, GF(2^8) log/exp tables and tower helper functions
// for the binary tower field multiplier. No dependencies.
package btfm_pkg;

  localparam int NumLeaves = 81;
  localparam int NumStages = 8;

  typedef logic [NumLeaves-1:0][7:0]  leaf_vec_t;
  typedef logic [NumLeaves-1:0]       leaf_flag_t;
  typedef logic [NumStages-1:0]       stage_vec_t;

  localparam logic [7:0] GF8_EXP [256] = '{
    8'h01, 8'h13, 8'h43, 8'h66, 8'hab, 8'h8c, 8'h60, 8'hc6,
    8'h91, 8'hca, 8'h59, 8'hb2, 8'h6a, 8'h63, 8'hf4, 8'h53,
    8'h17, 8'h0f, 8'hfa, 8'hba, 8'hee, 8'h87, 8'hd6, 8'he0,
    8'h6e, 8'h2f, 8'h68, 8'h42, 8'h75, 8'he8, 8'hea, 8'hcb,
    8'h4a, 8'hf1, 8'h0c, 8'hc8, 8'h78, 8'h33, 8'hd1, 8'h9e,
    8'h30, 8'he3, 8'h5c, 8'hed, 8'hb5, 8'h14, 8'h3d, 8'h38,
    8'h67, 8'hb8, 8'hcf, 8'h06, 8'h6d, 8'h1d, 8'haa, 8'h9f,
    8'h23, 8'ha0, 8'h3a, 8'h46, 8'h39, 8'h74, 8'hfb, 8'ha9,
    8'had, 8'he1, 8'h7d, 8'h6c, 8'h0e, 8'he9, 8'hf9, 8'h88,
    8'h2c, 8'h5a, 8'h80, 8'ha8, 8'hbe, 8'ha2, 8'h1b, 8'hc7,
    8'h82, 8'h89, 8'h3f, 8'h19, 8'he6, 8'h03, 8'h32, 8'hc2,
    8'hdd, 8'h56, 8'h48, 8'hd0, 8'h8d, 8'h73, 8'h85, 8'hf7,
    8'h61, 8'hd5, 8'hd2, 8'hac, 8'hf2, 8'h3e, 8'h0a, 8'ha5,
    8'h65, 8'h99, 8'h4e, 8'hbd, 8'h90, 8'hd9, 8'h1a, 8'hd4,
    8'hc1, 8'hef, 8'h94, 8'h95, 8'h86, 8'hc5, 8'ha3, 8'h08,
    8'h84, 8'he4, 8'h22, 8'hb3, 8'h79, 8'h20, 8'h92, 8'hf8,
    8'h9b, 8'h6f, 8'h3c, 8'h2b, 8'h24, 8'hde, 8'h64, 8'h8a,
    8'h0d, 8'hdb, 8'h3b, 8'h55, 8'h7a, 8'h12, 8'h50, 8'h25,
    8'hcd, 8'h27, 8'hec, 8'ha6, 8'h57, 8'h5b, 8'h93, 8'heb,
    8'hd8, 8'h09, 8'h97, 8'ha7, 8'h44, 8'h18, 8'hf5, 8'h40,
    8'h54, 8'h69, 8'h51, 8'h36, 8'h8e, 8'h41, 8'h47, 8'h2a,
    8'h37, 8'h9d, 8'h02, 8'h21, 8'h81, 8'hbb, 8'hfd, 8'hc4,
    8'hb0, 8'h4b, 8'he2, 8'h4f, 8'hae, 8'hd3, 8'hbf, 8'hb1,
    8'h58, 8'ha1, 8'h29, 8'h05, 8'h5f, 8'hdf, 8'h77, 8'hc9,
    8'h6b, 8'h70, 8'hb7, 8'h35, 8'hbc, 8'h83, 8'h9a, 8'h7c,
    8'h7f, 8'h4d, 8'h8f, 8'h52, 8'h04, 8'h4c, 8'h9c, 8'h11,
    8'h62, 8'he7, 8'h10, 8'h71, 8'ha4, 8'h76, 8'hda, 8'h28,
    8'h16, 8'h1c, 8'hb9, 8'hdc, 8'h45, 8'h0b, 8'hb6, 8'h26,
    8'hff, 8'he5, 8'h31, 8'hf0, 8'h1f, 8'h8b, 8'h1e, 8'h98,
    8'h5d, 8'hfe, 8'hf6, 8'h72, 8'h96, 8'hb4, 8'h07, 8'h7e,
    8'h5e, 8'hcc, 8'h34, 8'haf, 8'hc0, 8'hfc, 8'hd7, 8'hf3,
    8'h2d, 8'h49, 8'hc3, 8'hce, 8'h15, 8'h2e, 8'h7b, 8'h00
  };

  localparam logic [7:0] GF8_LOG [256] = '{
    8'h00, 8'h00, 8'haa, 8'h55, 8'hcc, 8'hbb, 8'h33, 8'hee,
    8'h77, 8'h99, 8'h66, 8'hdd, 8'h22, 8'h88, 8'h44, 8'h11,
    8'hd2, 8'hcf, 8'h8d, 8'h01, 8'h2d, 8'hfc, 8'hd8, 8'h10,
    8'h9d, 8'h53, 8'h6e, 8'h4e, 8'hd9, 8'h35, 8'he6, 8'he4,
    8'h7d, 8'hab, 8'h7a, 8'h38, 8'h84, 8'h8f, 8'hdf, 8'h91,
    8'hd7, 8'hba, 8'ha7, 8'h83, 8'h48, 8'hf8, 8'hfd, 8'h19,
    8'h28, 8'he2, 8'h56, 8'h25, 8'hf2, 8'hc3, 8'ha3, 8'ha8,
    8'h2f, 8'h3c, 8'h3a, 8'h8a, 8'h82, 8'h2e, 8'h65, 8'h52,
    8'h9f, 8'ha5, 8'h1b, 8'h02, 8'h9c, 8'hdc, 8'h3b, 8'ha6,
    8'h5a, 8'hf9, 8'h20, 8'hb1, 8'hcd, 8'hc9, 8'h6a, 8'hb3,
    8'h8e, 8'ha2, 8'hcb, 8'h0f, 8'ha0, 8'h8b, 8'h59, 8'h94,
    8'hb8, 8'h0a, 8'h49, 8'h95, 8'h2a, 8'he8, 8'hf0, 8'hbc,
    8'h06, 8'h60, 8'hd0, 8'h0d, 8'h86, 8'h68, 8'h03, 8'h30,
    8'h1a, 8'ha1, 8'h0c, 8'hc0, 8'h43, 8'h34, 8'h18, 8'h81,
    8'hc1, 8'hd3, 8'heb, 8'h5d, 8'h3d, 8'h1c, 8'hd5, 8'hbe,
    8'h24, 8'h7c, 8'h8c, 8'hfe, 8'hc7, 8'h42, 8'hef, 8'hc8,
    8'h4a, 8'hac, 8'h50, 8'hc5, 8'h78, 8'h5e, 8'h74, 8'h15,
    8'h47, 8'h51, 8'h87, 8'he5, 8'h05, 8'h5c, 8'ha4, 8'hca,
    8'h6c, 8'h08, 8'h7e, 8'h96, 8'h72, 8'h73, 8'hec, 8'h9a,
    8'he7, 8'h69, 8'hc6, 8'h80, 8'hce, 8'ha9, 8'h27, 8'h37,
    8'h39, 8'hb9, 8'h4d, 8'h76, 8'hd4, 8'h67, 8'h93, 8'h9b,
    8'h4b, 8'h3f, 8'h36, 8'h04, 8'h63, 8'h40, 8'hb4, 8'hf3,
    8'hb0, 8'hb7, 8'h0b, 8'h7b, 8'hed, 8'h2c, 8'hde, 8'hc2,
    8'h31, 8'hda, 8'h13, 8'had, 8'hc4, 8'h6b, 8'h4c, 8'hb6,
    8'hf4, 8'h70, 8'h57, 8'hfa, 8'haf, 8'h75, 8'h07, 8'h4f,
    8'h23, 8'hbf, 8'h09, 8'h1f, 8'hf1, 8'h90, 8'hfb, 8'h32,
    8'h5b, 8'h26, 8'h62, 8'hb5, 8'h6f, 8'h61, 8'h16, 8'hf6,
    8'h98, 8'h6d, 8'hd6, 8'h89, 8'hdb, 8'h58, 8'h85, 8'hbd,
    8'h17, 8'h41, 8'hb2, 8'h29, 8'h79, 8'he1, 8'h54, 8'hd1,
    8'h1d, 8'h45, 8'h1e, 8'h97, 8'h92, 8'h2b, 8'h14, 8'h71,
    8'he3, 8'h21, 8'h64, 8'hf7, 8'h0e, 8'h9e, 8'hea, 8'h5f,
    8'h7f, 8'h46, 8'h12, 8'h3e, 8'hf5, 8'hae, 8'he9, 8'he0
  };

  // Multiplicative order of the GF(2^8) generator
  localparam logic [8:0] GF8_ORDER = 9'd255;
  // Tower generator of the 8-bit level as a GF(2^8) element
  localparam logic [7:0] GF8_GEN = 8'h10;

  function automatic logic [7:0] gf8_mul(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, GF8_LOG[x]} + {1'b0, GF8_LOG[y]};
    if (s >= GF8_ORDER) s = s - GF8_ORDER;
    return (x == 8'h0 || y == 8'h0) ? 8'h0 : GF8_EXP[s[7:0]];
  endfunction

  // Multiply by the tower generator of each level: X*(lo + hi*X) = hi + (lo + g*hi)*X
  function automatic logic [7:0] mulx8(input logic [7:0] v);
    return gf8_mul(GF8_GEN, v);
  endfunction

  function automatic logic [15:0] mulx16(input logic [15:0] v);
    return {v[7:0] ^ mulx8(v[15:8]), v[15:8]};
  endfunction

  function automatic logic [31:0] mulx32(input logic [31:0] v);
    return {v[15:0] ^ mulx16(v[31:16]), v[31:16]};
  endfunction

  function automatic logic [63:0] mulx64(input logic [63:0] v);
    return {v[31:0] ^ mulx32(v[63:32]), v[63:32]};
  endfunction

  // Karatsuba recombination: lo = ll+hh, hi = mid+ll+hh+X*hh
  function automatic logic [15:0] comb16(input logic [7:0] ll, input logic [7:0] hh,
                                         input logic [7:0] mid);
    return {mid ^ ll ^ hh ^ mulx8(hh), ll ^ hh};
  endfunction

  function automatic logic [31:0] comb32(input logic [15:0] ll, input logic [15:0] hh,
                                         input logic [15:0] mid);
    return {mid ^ ll ^ hh ^ mulx16(hh), ll ^ hh};
  endfunction

  function automatic logic [63:0] comb64(input logic [31:0] ll, input logic [31:0] hh,
                                         input logic [31:0] mid);
    return {mid ^ ll ^ hh ^ mulx32(hh), ll ^ hh};
  endfunction

  function automatic logic [127:0] comb128(input logic [63:0] ll, input logic [63:0] hh,
                                           input logic [63:0] mid);
    return {mid ^ ll ^ hh ^ mulx64(hh), ll ^ hh};
  endfunction

endpackage

// ----- rtl/btfm_in_if.sv -----
// Operand channel: valid/ready handshake with two 128-bit tower operands.
// No dependencies.
interface btfm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] a_low;
  logic [63:0] a_high;
  logic [63:0] b_low;
  logic [63:0] b_high;
  modport source(output valid, a_low, a_high, b_low, b_high, input ready);
  modport sink(input valid, a_low, a_high, b_low, b_high, output ready);
endinterface

// ----- rtl/btfm_out_if.sv -----
// Product channel: valid/ready handshake with the 128-bit tower product.
// No dependencies.
interface btfm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] product_low;
  logic [63:0] product_high;
  modport source(output valid, product_low, product_high, input ready);
  modport sink(input valid, product_low, product_high, output ready);
endinterface

// ----- rtl/btfm_base_mul.sv -----
// 81 parallel GF(2^8) multiplies over three stages: log, add, exp.
// Depends on btfm_pkg.
module btfm_base_mul
  import btfm_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] en,
  input  leaf_vec_t  leaf_a,
  input  leaf_vec_t  leaf_b,
  output leaf_vec_t  prod
);

  leaf_vec_t  log_a, log_b;
  leaf_flag_t zero1, zero2;
  leaf_vec_t  idx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NumLeaves; i++) begin
        log_a[i] <= GF8_LOG[leaf_a[i]];
        log_b[i] <= GF8_LOG[leaf_b[i]];
        zero1[i] <= (leaf_a[i] == 8'h0) || (leaf_b[i] == 8'h0);
      end
    end
  end

  // log sum reduced once by the group order
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NumLeaves; i++) begin
        logic [8:0] s;
        s = {1'b0, log_a[i]} + {1'b0, log_b[i]};
        if (s >= GF8_ORDER) s = s - GF8_ORDER;
        idx[i]   <= s[7:0];
        zero2[i] <= zero1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NumLeaves; i++) begin
        prod[i] <= zero2[i] ? 8'h0 : GF8_EXP[idx[i]];
      end
    end
  end

endmodule

// ----- rtl/btfm_recombine.sv -----
// Karatsuba recombination, one tower level per stage: 8->16->32->64->128.
// Depends on btfm_pkg.
module btfm_recombine
  import btfm_pkg::*;
(
  input  logic           clk,
  input  logic [3:0]     en,
  input  leaf_vec_t      prod8,
  output logic [127:0]   prod128
);

  logic [26:0][15:0] p16;
  logic [8:0][31:0]  p32;
  logic [2:0][63:0]  p64;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 27; i++) begin
        p16[i] <= comb16(prod8[3*i], prod8[3*i+1], prod8[3*i+2]);
      end
    end
    if (en[1]) begin
      for (int i = 0; i < 9; i++) begin
        p32[i] <= comb32(p16[3*i], p16[3*i+1], p16[3*i+2]);
      end
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        p64[i] <= comb64(p32[3*i], p32[3*i+1], p32[3*i+2]);
      end
    end
    if (en[3]) begin
      prod128 <= comb128(p64[0], p64[1], p64[2]);
    end
  end

endmodule

// ----- rtl/binary_tower_field_multiplier_unit.sv -----
// Top level of the GF(2^128) binary tower field multiplier.
// Depends on btfm_pkg, btfm_in_if, btfm_out_if, btfm_base_mul, btfm_recombine.
//
//   channel    dir  beat contents
//   operands   in   a_low, a_high, b_low, b_high (64 bits each)
//   product    out  product_low, product_high (64 bits each)
//
// Eight register stages: operand split, log lookup, log add, exp lookup,
// then four Karatsuba recombination levels. One beat is taken and one
// product given per cycle when not stalled, set by the 81 parallel GF(2^8)
// lanes. Each stage loads when empty or when the stage after it moves, so
// bubbles are squeezed out under stall. rst clears only the valid bits.
module binary_tower_field_multiplier_unit
  import btfm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  btfm_in_if.sink    operands,
  btfm_out_if.source product
);

  stage_vec_t vld;
  stage_vec_t en;

  // per-stage load enables, rippling back from the output
  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || product.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign operands.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= operands.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Karatsuba operand tree: each node gives lo, hi and lo^hi children
  logic [2:0][63:0]  a64, b64;
  logic [8:0][31:0]  a32, b32;
  logic [26:0][15:0] a16, b16;
  leaf_vec_t         a8, b8;

  always_comb begin
    a64[0] = operands.a_low;
    a64[1] = operands.a_high;
    a64[2] = operands.a_low ^ operands.a_high;
    b64[0] = operands.b_low;
    b64[1] = operands.b_high;
    b64[2] = operands.b_low ^ operands.b_high;
    for (int i = 0; i < 3; i++) begin
      a32[3*i]   = a64[i][31:0];
      a32[3*i+1] = a64[i][63:32];
      a32[3*i+2] = a64[i][31:0] ^ a64[i][63:32];
      b32[3*i]   = b64[i][31:0];
      b32[3*i+1] = b64[i][63:32];
      b32[3*i+2] = b64[i][31:0] ^ b64[i][63:32];
    end
    for (int i = 0; i < 9; i++) begin
      a16[3*i]   = a32[i][15:0];
      a16[3*i+1] = a32[i][31:16];
      a16[3*i+2] = a32[i][15:0] ^ a32[i][31:16];
      b16[3*i]   = b32[i][15:0];
      b16[3*i+1] = b32[i][31:16];
      b16[3*i+2] = b32[i][15:0] ^ b32[i][31:16];
    end
    for (int i = 0; i < 27; i++) begin
      a8[3*i]   = a16[i][7:0];
      a8[3*i+1] = a16[i][15:8];
      a8[3*i+2] = a16[i][7:0] ^ a16[i][15:8];
      b8[3*i]   = b16[i][7:0];
      b8[3*i+1] = b16[i][15:8];
      b8[3*i+2] = b16[i][7:0] ^ b16[i][15:8];
    end
  end

  leaf_vec_t leaf_a, leaf_b;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      leaf_a <= a8;
      leaf_b <= b8;
    end
  end

  leaf_vec_t    prod8;
  logic [127:0] prod128;

  btfm_base_mul u_base_mul (
    .clk    (clk),
    .en     (en[3:1]),
    .leaf_a (leaf_a),
    .leaf_b (leaf_b),
    .prod   (prod8)
  );

  btfm_recombine u_recombine (
    .clk     (clk),
    .en      (en[7:4]),
    .prod8   (prod8),
    .prod128 (prod128)
  );

  assign product.valid        = vld[NumStages-1];
  assign product.product_low  = prod128[63:0];
  assign product.product_high = prod128[127:64];

  // reset empties the whole pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // an accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> vld[0])
    else $error("accepted beat lost at entry");

  // a stalled full stage 4 (vld[4]) never loses its item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !en[4] |=> vld[4])
    else $error("stalled item dropped");

  // the output result is kept while stalled
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    product.valid && !product.ready |=> product.valid && $stable(prod128))
    else $error("stalled product changed");

endmodule
